// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the PRNG top-level unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/cmxr_pkg.sv -----
// ----------------------------------------------------------------------------
// cmxr_pkg
// Constants, types and helper functions of the counter multiply-xor-rotate PRNG.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmxr_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned CntWidth  = 64;

  localparam logic [WordWidth-1:0] MixA1 = 32'hD747_4D0B;
  localparam logic [WordWidth-1:0] MixA2 = 32'hE293_A7BD;

  localparam logic [4:0] Rot1R1 = 5'd30;
  localparam logic [4:0] Rot1R2 = 5'd6;
  localparam logic [4:0] Rot2R1 = 5'd26;
  localparam logic [4:0] Rot2R2 = 5'd23;

  localparam logic [1:0] PhaseNewBlock = 2'd2;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [CntWidth-1:0]  cnt_t;

  typedef struct packed {
    logic start_block;
    logic mul;
    logic mix;
    logic round;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_block;
  } status_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] r);
    return (x << r) | (x >> (6'd32 - {1'b0, r}));
  endfunction

endpackage

// ----- design/cmxr_draw_if.sv -----
// ----------------------------------------------------------------------------
// cmxr_draw_if
// Request channel carrying one draw flag per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmxr_draw_if;
  logic valid;
  logic ready;
  logic draw;

  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

// ----- design/cmxr_word_if.sv -----
// ----------------------------------------------------------------------------
// cmxr_word_if
// Result channel carrying one 32-bit random word per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cmxr_word_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ----- design/cmxr_datapath.sv -----
// ----------------------------------------------------------------------------
// cmxr_datapath
// Counter, block halves, product register, phase and output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmxr_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_we,
  input  cmxr_pkg::cnt_t    seed_data,
  input  cmxr_pkg::cmd_t    cmd,
  output cmxr_pkg::status_t status,
  output cmxr_pkg::word_t   word
);

  cmxr_pkg::cnt_t  counter;
  cmxr_pkg::cnt_t  counter_next;
  cmxr_pkg::word_t h0;
  cmxr_pkg::word_t h1;
  logic [63:0]     prod;
  logic [1:0]      phase;
  cmxr_pkg::word_t word_q;

  cmxr_pkg::word_t mul_const;
  cmxr_pkg::word_t hx;
  cmxr_pkg::word_t rot_a;
  cmxr_pkg::word_t h0_mix;
  cmxr_pkg::word_t rot_b;
  cmxr_pkg::word_t h1_mix;

  assign counter_next = counter + 64'd1;
  assign mul_const    = cmd.round ? cmxr_pkg::MixA2 : cmxr_pkg::MixA1;
  assign hx           = h1 ^ prod[63:32];
  assign rot_a        = cmd.round ? cmxr_pkg::rotl(hx, cmxr_pkg::Rot2R1)
                                  : cmxr_pkg::rotl(hx, cmxr_pkg::Rot1R1);
  assign h0_mix       = prod[31:0] + rot_a;
  assign rot_b        = cmd.round ? cmxr_pkg::rotl(h0_mix, cmxr_pkg::Rot2R2)
                                  : cmxr_pkg::rotl(h0_mix, cmxr_pkg::Rot1R2);
  assign h1_mix       = hx + rot_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      phase   <= cmxr_pkg::PhaseNewBlock;
    end else if (seed_we) begin
      counter <= seed_data;
      phase   <= cmxr_pkg::PhaseNewBlock;
    end else if (cmd.start_block) begin
      counter <= counter_next;
      phase   <= 2'd0;
    end else if (cmd.emit) begin
      phase   <= phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      h0 <= counter_next[31:0];
      h1 <= counter_next[63:32];
    end else if (cmd.mix) begin
      h0 <= h0_mix;
      h1 <= h1_mix;
    end
    if (cmd.mul) begin
      prod <= 64'(mul_const) * 64'(h0 ^ h1);
    end
    if (cmd.emit) begin
      word_q <= phase[0] ? h1 : h0;
    end
  end

  assign status.need_block = phase[1];
  assign word              = word_q;

endmodule

// ----- design/cmxr_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmxr_ctrl
// Sequencer for draw acceptance, the two mixing rounds and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmxr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_draw,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cmxr_pkg::status_t status,
  output cmxr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MIX1,
    ST_MUL2,
    ST_MIX2,
    ST_EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd             = '0;
    cmd.start_block = accept && in_draw && status.need_block;
    cmd.mul         = (state == ST_MUL1) || (state == ST_MUL2);
    cmd.mix         = (state == ST_MIX1) || (state == ST_MIX2);
    cmd.round       = (state == ST_MUL2) || (state == ST_MIX2);
    cmd.emit        = (state == ST_EMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && in_draw) begin
            state <= status.need_block ? ST_MUL1 : ST_EMIT;
          end
        end
        ST_MUL1: state <= ST_MIX1;
        ST_MIX1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MIX2;
        ST_MIX2: state <= ST_EMIT;
        ST_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/counter_mul_xor_rotate_prng_unit.sv -----
// ----------------------------------------------------------------------------
// counter_mul_xor_rotate_prng_unit
// Counter-based 32-bit random word generator with multiply-xor-rotate mixing.
// ----------------------------------------------------------------------------
// Each transfer on draw_ch requests one word; a transfer with draw low is
// consumed and produces nothing. Words leave on word_ch, low half of a block
// first, then the high half. Every second word starts a new block: the 64-bit
// counter is incremented and mixed by two rounds, each a 32x32 multiply into
// a registered product followed by a rotate-add step on that product.
// A word that starts a block passes the states MUL1, MIX1, MUL2, MIX2 and
// EMIT before it is loaded into the output register, and the next request is
// taken only once the sequencer is back in idle; a second half goes straight
// to EMIT. The two rounds share one multiply and mix unit, selecting their
// constants and rotations by round. A finished word waits in the
// output register, and the next request is taken meanwhile; if the receiver
// stalls, the following word waits in the sequencer until the register is
// free, and the request channel stays stalled until then.
// Writing cfg_wr_data with cfg_wr_en loads the counter and forces a new
// block on the next draw; write only while no request is in flight.
// Reset clears the counter to zero and marks that a new block is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module counter_mul_xor_rotate_prng_unit (
  input  logic                 clk,
  input  logic                 rst,
  cmxr_draw_if.sink            draw_ch,
  cmxr_word_if.source          word_ch,
  input  logic                 cfg_wr_en,
  input  cmxr_pkg::cnt_t       cfg_wr_data
);

  cmxr_pkg::cmd_t    cmd;
  cmxr_pkg::status_t status;
  logic              in_ready;
  logic              out_valid;
  cmxr_pkg::word_t   word;

  cmxr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (draw_ch.valid),
    .in_draw   (draw_ch.draw),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (word_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cmxr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (cfg_wr_en),
    .seed_data (cfg_wr_data),
    .cmd       (cmd),
    .status    (status),
    .word      (word)
  );

  assign draw_ch.ready = in_ready;
  assign word_ch.valid = out_valid;
  assign word_ch.word  = word;

  // An empty request is consumed without tying up the sequencer.
  `ASSERT_NEXT(a_empty_draw_keeps_ready, clk, rst,
    draw_ch.valid && draw_ch.ready && !draw_ch.draw, draw_ch.ready)
  // A real request takes the sequencer out of idle, so it is not ready in the next cycle.
  `ASSERT_NEXT(a_draw_busy, clk, rst,
    draw_ch.valid && draw_ch.ready && draw_ch.draw, !draw_ch.ready)
  // A seed write always forces a fresh block.
  `ASSERT_NEXT(a_seed_forces_block, clk, rst, cfg_wr_en, status.need_block)
  // A new block is only started from the idle state with a real request.
  `ASSERT_SAME(a_start_on_request, clk, rst, cmd.start_block,
    draw_ch.valid && draw_ch.ready && draw_ch.draw)

endmodule
